/* sv/quaternion_to_euler_bins_defines.svh */
// Assertion helpers used by quaternion_to_euler_bins.sv.
`ifndef QUATERNION_TO_EULER_BINS_DEFINES_SVH
`define QUATERNION_TO_EULER_BINS_DEFINES_SVH

// Property that holds at every clock edge outside reset.
`define Q2E_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in a cycle implies consequent in the next.
`define Q2E_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/q2e_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package q2e_pkg;

    localparam int BIN_COUNT     = 18;
    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_TAB_LEN  = 24;
    localparam int CORDIC_USED   = (CORDIC_STAGES < ATAN_TAB_LEN) ? CORDIC_STAGES : ATAN_TAB_LEN;
    localparam int BW            = 8;   // bin width before masking
    localparam int QW            = 16;  // input component width
    localparam int MW            = 32;  // product width
    localparam int PW            = 34;  // Q28 argument width
    localparam int VW            = 38;  // CORDIC vector width
    localparam int ZW            = 35;  // binary angle width
    localparam int NW            = 57;  // square root radicand width
    localparam int SQRT_STEPS    = 29;
    localparam int SHW           = 5;

    localparam logic signed [ZW-1:0] HALF_TURN    = ZW'(64'sd2147483648);
    localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(64'sd1073741824);
    localparam logic signed [PW-1:0] ONE_Q28      = PW'(64'sd268435456);
    localparam logic [NW-1:0]        ONE_SQ       = NW'(1) << 56;

    typedef struct packed {
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 hold;  // angle already final
    } vec_t;

    typedef vec_t [2:0] vec3_t;      // roll, pitch, yaw

    typedef struct packed {
        logic [NW-1:0] n;
        logic [NW-1:0] r;
    } root_t;

    typedef struct packed {
        logic signed [PW-1:0] roll_n;
        logic signed [PW-1:0] roll_d;
        logic signed [PW-1:0] yaw_n;
        logic signed [PW-1:0] yaw_d;
        logic signed [PW-1:0] s;
    } pay_t;

    function automatic logic signed [ZW-1:0] atan_turn(input logic [SHW-1:0] idx);
        logic [31:0] a;
        case (idx)
            5'd0:    a = 32'h20000000;
            5'd1:    a = 32'h12E4051D;
            5'd2:    a = 32'h09FB385B;
            5'd3:    a = 32'h051111D4;
            5'd4:    a = 32'h028B0D43;
            5'd5:    a = 32'h0145D7E1;
            5'd6:    a = 32'h00A2F61E;
            5'd7:    a = 32'h00517C55;
            5'd8:    a = 32'h0028BE53;
            5'd9:    a = 32'h00145F2E;
            5'd10:   a = 32'h000A2F98;
            5'd11:   a = 32'h000517CC;
            5'd12:   a = 32'h00028BE6;
            5'd13:   a = 32'h000145F3;
            5'd14:   a = 32'h0000A2F9;
            5'd15:   a = 32'h0000517C;
            5'd16:   a = 32'h000028BE;
            5'd17:   a = 32'h0000145F;
            5'd18:   a = 32'h00000A2F;
            5'd19:   a = 32'h00000517;
            5'd20:   a = 32'h0000028B;
            5'd21:   a = 32'h00000145;
            5'd22:   a = 32'h000000A2;
            5'd23:   a = 32'h00000051;
            default: a = 32'h0;
        endcase
        return $signed({{(ZW-32){1'b0}}, a});
    endfunction

endpackage

`default_nettype wire

/* sv/q2e_sqrt_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

// One digit of the restoring square root; carries the angle arguments along.
module q2e_sqrt_cell (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic [q2e_pkg::NW-1:0] step_bit,
    input  wire logic              in_valid,
    input  wire q2e_pkg::root_t    in_root,
    input  wire q2e_pkg::pay_t     in_pay,
    output logic                   out_valid,
    output q2e_pkg::root_t         out_root,
    output q2e_pkg::pay_t          out_pay
);

    logic [q2e_pkg::NW-1:0] trial;
    q2e_pkg::root_t         root_next;

    always_comb
    begin
        trial = in_root.r + step_bit;
        if (in_root.n >= trial)
        begin
            root_next.n = in_root.n - trial;
            root_next.r = (in_root.r >> 1) + step_bit;
        end
        else
        begin
            root_next.n = in_root.n;
            root_next.r = in_root.r >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (en)
            out_valid <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_root <= root_next;
            out_pay  <= in_pay;
        end
    end

endmodule

`default_nettype wire

/* sv/q2e_cordic_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

// One vectoring CORDIC micro-rotation for the roll, pitch and yaw vectors.
module q2e_cordic_cell (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     en,
    input  wire logic [q2e_pkg::SHW-1:0]  shift,
    input  wire logic                     in_valid,
    input  wire q2e_pkg::vec3_t           in_vec,
    output logic                          out_valid,
    output q2e_pkg::vec3_t                out_vec
);

    q2e_pkg::vec3_t             vec_next;
    logic signed [q2e_pkg::ZW-1:0] step_ang;

    assign step_ang = q2e_pkg::atan_turn(shift);

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            vec_next[k] = in_vec[k];
            if (!in_vec[k].hold)
            begin
                if (in_vec[k].y > 0)
                begin
                    vec_next[k].x = in_vec[k].x + (in_vec[k].y >>> shift);
                    vec_next[k].y = in_vec[k].y - (in_vec[k].x >>> shift);
                    vec_next[k].z = in_vec[k].z + step_ang;
                end
                else
                begin
                    vec_next[k].x = in_vec[k].x - (in_vec[k].y >>> shift);
                    vec_next[k].y = in_vec[k].y + (in_vec[k].x >>> shift);
                    vec_next[k].z = in_vec[k].z - step_ang;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (en)
            out_valid <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_vec <= vec_next;
    end

endmodule

`default_nettype wire

/* sv/quaternion_to_euler_bins.sv */
`timescale 1ns / 1ps
`default_nettype none
// Quaternion to quantized Euler angles.
// Input channel s_axis: one word per unit quaternion, w, x, y, z as signed Q1.14.
// Output channel m_axis: one word per input word with roll, pitch and yaw bins
// (0..BIN_COUNT, truncated) and volume = BIN_COUNT - pitch bin.
// Pipeline: products, argument sums, square of the pitch sine, 29 root-digit
// cells for the pitch cosine, an atan2 setup stage, CORDIC_USED CORDIC cells
// (CORDIC_STAGES, capped at the atan table length), then the output register.
// Throughput is one word per cycle while m_axis is not stalled; every stage
// hands its word to the next one each clock that the chain advances.
// When the receiver stalls with a word waiting, the whole chain holds and
// s_axis_tready drops; nothing is lost or duplicated. Bubbles in the chain
// are not squeezed out during a stall.
// Reset (rst_n low, asynchronous) clears all valid flags; data registers
// keep whatever they held. No configuration, no state between words.
`include "quaternion_to_euler_bins_defines.svh"

module quaternion_to_euler_bins (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [63:0] s_axis_tdata,   // quat_w[15:0], quat_x[31:16],
                                             // quat_y[47:32], quat_z[63:48]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata    // roll_bin[4:0], pitch_bin[9:5], yaw_bin[14:10],
                                             // volume_level[19:15], zero pad [23:20]
);

    localparam int QW = q2e_pkg::QW;
    localparam int MW = q2e_pkg::MW;
    localparam int PW = q2e_pkg::PW;
    localparam int VW = q2e_pkg::VW;
    localparam int ZW = q2e_pkg::ZW;
    localparam int NW = q2e_pkg::NW;
    localparam int BW = q2e_pkg::BW;
    localparam int SQ = q2e_pkg::SQRT_STEPS;
    localparam int CS = q2e_pkg::CORDIC_USED;

    // advance the whole chain unless a finished word waits
    logic en;
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    // ---- stage 1: component products
    logic signed [QW-1:0] qw, qx, qy, qz;
    assign qw = $signed(s_axis_tdata[15:0]);
    assign qx = $signed(s_axis_tdata[31:16]);
    assign qy = $signed(s_axis_tdata[47:32]);
    assign qz = $signed(s_axis_tdata[63:48]);

    logic                 v1_reg;
    logic signed [MW-1:0] wx_reg, yz_reg, xx_reg, yy_reg, wz_reg, xy_reg, zz_reg, wy_reg, zx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wx_reg <= qw * qx;
            yz_reg <= qy * qz;
            xx_reg <= qx * qx;
            yy_reg <= qy * qy;
            wz_reg <= qw * qz;
            xy_reg <= qx * qy;
            zz_reg <= qz * qz;
            wy_reg <= qw * qy;
            zx_reg <= qz * qx;
        end
    end

    // ---- stage 2: Q28 arguments, clamp the pitch sine
    logic                 v2_reg;
    q2e_pkg::pay_t        pay2_reg, pay2_next;
    logic signed [PW-1:0] s_raw;

    always_comb
    begin
        pay2_next.roll_n = PW'(wx_reg) + PW'(yz_reg);
        pay2_next.roll_n = pay2_next.roll_n <<< 1;
        pay2_next.roll_d = q2e_pkg::ONE_Q28 - ((PW'(xx_reg) + PW'(yy_reg)) <<< 1);
        pay2_next.yaw_n  = (PW'(wz_reg) + PW'(xy_reg)) <<< 1;
        pay2_next.yaw_d  = q2e_pkg::ONE_Q28 - ((PW'(yy_reg) + PW'(zz_reg)) <<< 1);
        s_raw            = (PW'(wy_reg) - PW'(zx_reg)) <<< 1;
        if (s_raw > q2e_pkg::ONE_Q28)
            pay2_next.s = q2e_pkg::ONE_Q28;
        else if (s_raw < -q2e_pkg::ONE_Q28)
            pay2_next.s = -q2e_pkg::ONE_Q28;
        else
            pay2_next.s = s_raw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            pay2_reg <= pay2_next;
    end

    // ---- stage 3: square of the clamped sine (|s| <= 2^28; +2^28 wraps to -2^28 in 29 signed bits, same square)
    logic                  v3_reg;
    q2e_pkg::pay_t         pay3_reg;
    logic [NW-1:0]         ssq_reg;
    logic signed [28:0]    s_short;
    logic signed [57:0]    ssq_full;

    assign s_short  = pay2_reg.s[28:0];
    assign ssq_full = s_short * s_short;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pay3_reg <= pay2_reg;
            ssq_reg  <= ssq_full[NW-1:0];
        end
    end

    // ---- root cells: cos = floor(sqrt(2^56 - s^2)), one digit per cell
    logic           sq_valid [SQ+1];
    q2e_pkg::root_t sq_root  [SQ+1];
    q2e_pkg::pay_t  sq_pay   [SQ+1];

    assign sq_valid[0]  = v3_reg;
    assign sq_root[0].n = q2e_pkg::ONE_SQ - ssq_reg;
    assign sq_root[0].r = '0;
    assign sq_pay[0]    = pay3_reg;

    for (genvar g = 0; g < SQ; g++)
    begin : g_sqrt
        logic [NW-1:0] step_bit;
        assign step_bit = NW'(1) << (2 * (SQ - 1 - g));

        q2e_sqrt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .step_bit (step_bit),
            .in_valid (sq_valid[g]),
            .in_root  (sq_root[g]),
            .in_pay   (sq_pay[g]),
            .out_valid(sq_valid[g+1]),
            .out_root (sq_root[g+1]),
            .out_pay  (sq_pay[g+1])
        );
    end

    // ---- atan2 setup: axis cases finish here, left half plane flips by pi
    function automatic q2e_pkg::vec_t atan_setup(input logic signed [VW-1:0] y,
                                                 input logic signed [VW-1:0] x);
        q2e_pkg::vec_t v;
        v.x    = x;
        v.y    = y;
        v.z    = '0;
        v.hold = 1'b0;
        if (y == 0)
        begin
            v.hold = 1'b1;
            v.z    = (x < 0) ? q2e_pkg::HALF_TURN : '0;
        end
        else if (x == 0)
        begin
            v.hold = 1'b1;
            v.z    = (y > 0) ? q2e_pkg::QUARTER_TURN : -q2e_pkg::QUARTER_TURN;
        end
        else if (x < 0)
        begin
            v.z = (y > 0) ? q2e_pkg::HALF_TURN : -q2e_pkg::HALF_TURN;
            v.x = -x;
            v.y = -y;
        end
        return v;
    endfunction

    q2e_pkg::pay_t        sq_last;
    logic signed [VW-1:0] cos_v;
    logic                 vp_reg;
    q2e_pkg::vec3_t       vp_vec_reg, vp_next;

    assign sq_last = sq_pay[SQ];
    assign cos_v   = $signed({1'b0, sq_root[SQ].r[VW-2:0]});

    always_comb
    begin
        vp_next[0] = atan_setup(VW'(sq_last.roll_n), VW'(sq_last.roll_d));
        vp_next[1] = atan_setup(VW'(sq_last.s), cos_v);
        vp_next[2] = atan_setup(VW'(sq_last.yaw_n), VW'(sq_last.yaw_d));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vp_reg <= 1'b0;
        else if (en)
            vp_reg <= sq_valid[SQ];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            vp_vec_reg <= vp_next;
    end

    // ---- CORDIC cells
    logic           cd_valid [CS+1];
    q2e_pkg::vec3_t cd_vec   [CS+1];

    assign cd_valid[0] = vp_reg;
    assign cd_vec[0]   = vp_vec_reg;

    for (genvar g = 0; g < CS; g++)
    begin : g_cordic
        logic [q2e_pkg::SHW-1:0] shift;
        assign shift = q2e_pkg::SHW'(g);

        q2e_cordic_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .shift    (shift),
            .in_valid (cd_valid[g]),
            .in_vec   (cd_vec[g]),
            .out_valid(cd_valid[g+1]),
            .out_vec  (cd_vec[g+1])
        );
    end

    // ---- clamp and bin
    q2e_pkg::vec3_t       cd_last;
    logic signed [ZW-1:0] roll_a, pitch_a, yaw_a;
    logic [32:0]          roll_u, yaw_u;
    logic [31:0]          pitch_u;
    logic [40:0]          roll_p, yaw_p;
    logic [39:0]          pitch_p;
    logic [BW-1:0]        roll_b, pitch_b, yaw_b, vol_b;

    function automatic logic signed [ZW-1:0] clamp_ang(input logic signed [ZW-1:0] a,
                                                       input logic signed [ZW-1:0] lim);
        if (a > lim)
            return lim;
        else if (a < -lim)
            return -lim;
        return a;
    endfunction

    assign cd_last = cd_vec[CS];

    always_comb
    begin
        roll_a  = clamp_ang(cd_last[0].z, q2e_pkg::HALF_TURN);
        pitch_a = clamp_ang(clamp_ang(cd_last[1].z, q2e_pkg::HALF_TURN),
                            q2e_pkg::QUARTER_TURN);
        yaw_a   = clamp_ang(cd_last[2].z, q2e_pkg::HALF_TURN);
        roll_u  = 33'(roll_a + q2e_pkg::HALF_TURN);
        yaw_u   = 33'(yaw_a + q2e_pkg::HALF_TURN);
        pitch_u = 32'(pitch_a + q2e_pkg::QUARTER_TURN);
        roll_p  = 41'(roll_u) * 41'(q2e_pkg::BIN_COUNT);
        yaw_p   = 41'(yaw_u) * 41'(q2e_pkg::BIN_COUNT);
        pitch_p = 40'(pitch_u) * 40'(q2e_pkg::BIN_COUNT);
        roll_b  = roll_p[32 +: BW];
        yaw_b   = yaw_p[32 +: BW];
        pitch_b = pitch_p[31 +: BW];
        vol_b   = BW'(q2e_pkg::BIN_COUNT) - pitch_b;
    end

    // ---- output register
    logic [23:0] out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tvalid <= 1'b0;
        else if (en)
            m_axis_tvalid <= cd_valid[CS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_data_reg <= {4'b0, vol_b[4:0], yaw_b[4:0], pitch_b[4:0], roll_b[4:0]};
    end

    assign m_axis_tdata = out_data_reg;

    // ---- checks
    `Q2E_ASSERT_ALWAYS(a_vol_sum, !m_axis_tvalid ||
        (5'(m_axis_tdata[9:5] + m_axis_tdata[19:15]) == 5'(q2e_pkg::BIN_COUNT)),
        "volume and pitch bin do not add up to the bin count")
    `Q2E_ASSERT_ALWAYS(a_pad_zero, !m_axis_tvalid || (m_axis_tdata[23:20] == 4'b0),
        "output pad bits not zero")
    `Q2E_ASSERT_NEXT(a_enter, s_axis_tvalid && s_axis_tready, v1_reg,
        "accepted word did not enter the product stage")
    `Q2E_ASSERT_NEXT(a_hold_stall, m_axis_tvalid && !m_axis_tready,
        $stable(vp_reg) && $stable(v3_reg), "chain moved during a stall")

endmodule

`default_nettype wire

/* tb/tb_quaternion_to_euler_bins.sv */
`timescale 1ns / 1ps

module tb_quaternion_to_euler_bins;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 33 + q2e_pkg::CORDIC_STAGES + 20;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // quat_w[15:0], quat_x[31:16], quat_y[47:32], quat_z[63:48]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // roll_bin[4:0], pitch_bin[9:5], yaw_bin[14:10],
                                 // volume_level[19:15], pad [23:20]

    typedef struct packed {
        logic [4:0] volume_level;
        logic [4:0] yaw_bin;
        logic [4:0] pitch_bin;
        logic [4:0] roll_bin;
    } bins_t;

    bins_t bins_expected[$];
    int    error_count;
    int    idle_cycles;
    bit    calm;       // stretch with no idling on either side

    quaternion_to_euler_bins uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Arithmetic right shift rounds toward minus infinity already.
    function automatic longint atan2_turns(longint yi, longint xi);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        longint tab[24];
        tab = '{64'h20000000, 64'h12E4051D, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
                64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2E,
                64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2F9,
                64'h0000517C, 64'h000028BE, 64'h0000145F, 64'h00000A2F, 64'h00000517,
                64'h0000028B, 64'h00000145, 64'h000000A2, 64'h00000051};
        x = xi;
        y = yi;
        z = 0;
        if (y == 0)
            return (x < 0) ? 64'sd2147483648 : 0;
        if (x == 0)
            return (y > 0) ? 64'sd1073741824 : -64'sd1073741824;
        if (x < 0)
        begin
            z = (y > 0) ? 64'sd2147483648 : -64'sd2147483648;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < q2e_pkg::CORDIC_STAGES && i < 24; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0)
            begin
                x += dx;
                y -= dy;
                z += tab[i];
            end
            else
            begin
                x -= dx;
                y += dy;
                z -= tab[i];
            end
        end
        if (z > 64'sd2147483648)
            z = 64'sd2147483648;
        if (z < -64'sd2147483648)
            z = -64'sd2147483648;
        return z;
    endfunction

    function automatic longint root_floor(longint n);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic bins_t euler_bins(logic [63:0] q);
        longint w;
        longint x;
        longint y;
        longint z;
        longint s;
        longint c;
        longint roll;
        longint pitch;
        longint yaw;
        longint one;
        longint rb;
        longint pb;
        longint yb;
        bins_t  b;
        w = longint'($signed(q[15:0]));
        x = longint'($signed(q[31:16]));
        y = longint'($signed(q[47:32]));
        z = longint'($signed(q[63:48]));
        one = 64'sd1 << 28;
        s = 2 * (w * y - z * x);
        if (s > one)
            s = one;
        if (s < -one)
            s = -one;
        c = root_floor((64'sd1 << 56) - s * s);
        roll  = atan2_turns(2 * (w * x + y * z), one - 2 * (x * x + y * y));
        yaw   = atan2_turns(2 * (w * z + x * y), one - 2 * (y * y + z * z));
        pitch = atan2_turns(s, c);
        if (pitch > 64'sd1073741824)
            pitch = 64'sd1073741824;
        if (pitch < -64'sd1073741824)
            pitch = -64'sd1073741824;
        rb = ((roll + 64'sd2147483648) * q2e_pkg::BIN_COUNT) >>> 32;
        pb = ((pitch + 64'sd1073741824) * q2e_pkg::BIN_COUNT) >>> 31;
        yb = ((yaw + 64'sd2147483648) * q2e_pkg::BIN_COUNT) >>> 32;
        b.roll_bin     = rb[4:0];
        b.pitch_bin    = pb[4:0];
        b.yaw_bin      = yb[4:0];
        b.volume_level = 5'(q2e_pkg::BIN_COUNT - pb);
        return b;
    endfunction

    function automatic bit idle_now();
        return !calm && ($urandom_range(99) < 13);
    endfunction

    // Send one quaternion word; drop valid only for a random gap first.
    task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y, logic [15:0] z);
        if (idle_now())
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while (idle_now())
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {z, y, x, w};
        bins_expected.push_back(euler_bins({z, y, x, w}));
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    function automatic logic [15:0] rand_comp();
        case ($urandom_range(5))
            0:       return 16'($urandom_range(32768) - 16384);
            1:       return 16'($urandom);
            2:       return 16'($urandom_range(65535));
            default: return 16'(int'($urandom_range(200)) - 100);
        endcase
    endfunction

    // Receiver: random stall, compare each word against the oldest expectation.
    always @(posedge clk)
    begin
        bins_t got;
        bins_t want;
        if (rst_n)
        begin
            m_axis_tready <= !idle_now();
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[19:0];
                if (bins_expected.size() == 0)
                begin
                    $display("%0t: unexpected word %h", $time, m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    want = bins_expected.pop_front();
                    if (got.roll_bin !== want.roll_bin)
                    begin
                        $display("%0t: roll_bin expected %0d actual %0d",
                                 $time, want.roll_bin, got.roll_bin);
                        error_count++;
                    end
                    if (got.pitch_bin !== want.pitch_bin)
                    begin
                        $display("%0t: pitch_bin expected %0d actual %0d",
                                 $time, want.pitch_bin, got.pitch_bin);
                        error_count++;
                    end
                    if (got.yaw_bin !== want.yaw_bin)
                    begin
                        $display("%0t: yaw_bin expected %0d actual %0d",
                                 $time, want.yaw_bin, got.yaw_bin);
                        error_count++;
                    end
                    if (got.volume_level !== want.volume_level)
                    begin
                        $display("%0t: volume_level expected %0d actual %0d",
                                 $time, want.volume_level, got.volume_level);
                        error_count++;
                    end
                end
            end
        end
    end

    // Watchdog: count cycles with no accepted word on either side.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Axes, identity, special atan2 cases, clamp edges, extreme codes.
    task automatic test_directed();
        send_quat(16'sd16384, 0, 0, 0);
        send_quat(-16'sd16384, 0, 0, 0);
        send_quat(0, 16'sd16384, 0, 0);
        send_quat(0, -16'sd16384, 0, 0);
        send_quat(0, 0, 16'sd16384, 0);
        send_quat(0, 0, -16'sd16384, 0);
        send_quat(0, 0, 0, 16'sd16384);
        send_quat(0, 0, 0, -16'sd16384);
        send_quat(0, 0, 0, 0);
        send_quat(16'sd11585, 0, 16'sd11585, 0);
        send_quat(16'sd11585, 0, -16'sd11585, 0);
        send_quat(16'sd11585, 16'sd11585, 0, 0);
        send_quat(16'sd11585, 0, 0, 16'sd11585);
        send_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_quat(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000);
        send_quat(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_quat(16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF);
        send_quat(8192, 8192, 8192, 8192);
        send_quat(8192, -16'sd8192, 8192, -16'sd8192);
        send_quat(0, 16'sd11585, 16'sd11585, 0);
    endtask

    // Mostly small components within +-100, some within +-16384, some raw 16-bit patterns.
    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2)
                calm = 1'b1;
            if (i == count / 2 + 150)
                calm = 1'b0;
            send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
        end
    endtask

    initial
    begin
        error_count   = 0;
        idle_cycles   = 0;
        calm          = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(1130);
        s_axis_tvalid <= 1'b0;
        while (bins_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

/* quaternion_to_euler_bins.f */
+incdir+sv
sv/q2e_pkg.sv
sv/q2e_sqrt_cell.sv
sv/q2e_cordic_cell.sv
sv/quaternion_to_euler_bins.sv
tb/tb_quaternion_to_euler_bins.sv
